// ===== hdl/pat_pkg.sv =====
// Shared types, constants and helpers of the point affine transform block.
package pat_pkg;

   // Register file layout
   localparam int REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_MODE    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SHIFT_X = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SHIFT_Y = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_FACTOR  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_ANGLE   = 3'd4;

   typedef enum logic [1:0] {
      MODE_TRANSLATE = 2'd0,
      MODE_ENLARGE   = 2'd1,
      MODE_SHRINK    = 2'd2,
      MODE_ROTATE    = 2'd3
   } mode_type;

   // Divider: one quotient bit per stage over the 48-bit dividend
   localparam int NUM_W      = 48;
   localparam int DIV_STAGES = NUM_W;
   localparam int LANE_DLY   = DIV_STAGES;
   localparam int PIPE_DEPTH = DIV_STAGES + 2;

   // Angle arithmetic, Q16.16 degrees
   localparam int ANG_W = 28;
   localparam logic signed [ANG_W-1:0] DEG360 = 28'sd23592960;
   localparam logic signed [ANG_W-1:0] DEG180 = 28'sd11796480;
   localparam logic signed [ANG_W-1:0] DEG90  = 28'sd5898240;

   // Sine and cosine, Q2.30 with headroom
   localparam int TRIG_W = 34;
   localparam logic signed [TRIG_W-1:0] CORDIC_K = 34'sd652032875;
   localparam int CORDIC_STEPS = 18;

   typedef struct packed {
      logic                     busy;
      logic signed [TRIG_W-1:0] cos_v;
      logic signed [TRIG_W-1:0] sin_v;
      logic signed [TRIG_W-1:0] msin_v;
   } trig_type;

   // atan(2^-i) in Q16.16 degrees
   function automatic logic signed [ANG_W-1:0] atan_deg(input logic [4:0] idx);
      logic signed [ANG_W-1:0] v;
      unique case (idx)
         5'd0:    v = 28'sd2949120;
         5'd1:    v = 28'sd1740967;
         5'd2:    v = 28'sd919879;
         5'd3:    v = 28'sd466945;
         5'd4:    v = 28'sd234379;
         5'd5:    v = 28'sd117304;
         5'd6:    v = 28'sd58666;
         5'd7:    v = 28'sd29335;
         5'd8:    v = 28'sd14668;
         5'd9:    v = 28'sd7334;
         5'd10:   v = 28'sd3667;
         5'd11:   v = 28'sd1833;
         5'd12:   v = 28'sd917;
         5'd13:   v = 28'sd458;
         5'd14:   v = 28'sd229;
         5'd15:   v = 28'sd115;
         5'd16:   v = 28'sd57;
         5'd17:   v = 28'sd29;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Clamp a wide signed value to the signed 32-bit range
   function automatic logic [31:0] sat32(input logic signed [67:0] v);
      logic [31:0] r;
      if (v > 68'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -68'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/pat_sincos.sv =====
// Sequencer that reduces the rotation angle and runs a shared CORDIC for cos and sin.
module pat_sincos (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 restart,
   input  logic signed [25:0]   angle_in,
   output pat_pkg::trig_type    trig
);

   typedef enum logic [3:0] {
      SC_IDLE   = 4'b0001,
      SC_LOAD   = 4'b0010,
      SC_ROTATE = 4'b0100,
      SC_DONE   = 4'b1000
   } sc_state_type;

   sc_state_type state_ff, state_in;

   logic signed [pat_pkg::TRIG_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [pat_pkg::TRIG_W-1:0] cos_ff, cos_in, sin_ff, sin_in, msin_ff, msin_in;
   logic signed [pat_pkg::ANG_W-1:0]  z_ff, z_in;
   logic                              neg_ff, neg_in;
   logic [4:0]                        cnt_ff, cnt_in;

   logic signed [pat_pkg::ANG_W-1:0]  r0, r1, r2, r3, r4, zf;
   logic                              negf;
   logic signed [pat_pkg::TRIG_W-1:0] dx, dy;

   // Reduce the angle into [0, 360), then fold into [-90, 90]
   always_comb begin
      r0 = pat_pkg::ANG_W'(angle_in);
      r1 = (r0 >= pat_pkg::DEG360) ? r0 - pat_pkg::DEG360 : r0;
      r2 = (r1 < 0) ? r1 + pat_pkg::DEG360 : r1;
      r3 = (r2 < 0) ? r2 + pat_pkg::DEG360 : r2;
      r4 = (r3 > pat_pkg::DEG180) ? r3 - pat_pkg::DEG360 : r3;
      if (r4 > pat_pkg::DEG90) begin
         zf   = r4 - pat_pkg::DEG180;
         negf = 1'b1;
      end else if (r4 < -pat_pkg::DEG90) begin
         zf   = r4 + pat_pkg::DEG180;
         negf = 1'b1;
      end else begin
         zf   = r4;
         negf = 1'b0;
      end
   end

   // One CORDIC micro-rotation per cycle
   assign dx = cy_ff >>> cnt_ff;
   assign dy = cx_ff >>> cnt_ff;

   always_comb begin
      state_in = state_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      z_in     = z_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      cos_in   = cos_ff;
      sin_in   = sin_ff;
      msin_in  = msin_ff;
      unique case (state_ff)
         SC_LOAD: begin
            cx_in    = pat_pkg::CORDIC_K;
            cy_in    = '0;
            z_in     = zf;
            neg_in   = negf;
            cnt_in   = '0;
            state_in = SC_ROTATE;
         end
         SC_ROTATE: begin
            if (z_ff >= 0) begin
               cx_in = cx_ff - dx;
               cy_in = cy_ff + dy;
               z_in  = z_ff - pat_pkg::atan_deg(cnt_ff);
            end else begin
               cx_in = cx_ff + dx;
               cy_in = cy_ff - dy;
               z_in  = z_ff + pat_pkg::atan_deg(cnt_ff);
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(pat_pkg::CORDIC_STEPS - 1)) begin
               state_in = SC_DONE;
            end
         end
         SC_DONE: begin
            cos_in   = neg_ff ? -cx_ff : cx_ff;
            sin_in   = neg_ff ? -cy_ff : cy_ff;
            msin_in  = neg_ff ? cy_ff : -cy_ff;
            state_in = SC_IDLE;
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
      if (restart) begin
         state_in = SC_LOAD;
      end
   end

   // Hold control state; restart the sequence after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      z_ff    <= z_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
      msin_ff <= msin_in;
   end

   assign trig.busy   = (state_ff != SC_IDLE);
   assign trig.cos_v  = cos_ff;
   assign trig.sin_v  = sin_ff;
   assign trig.msin_v = msin_ff;

endmodule

// ===== hdl/pat_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
module pat_div (
   input  logic                      clock,
   input  logic [pat_pkg::NUM_W-1:0] num_in,
   input  logic [31:0]               den_in,
   input  logic                      neg_in,
   output logic [pat_pkg::NUM_W-1:0] quo,
   output logic                      neg_out
);

   localparam int NW = pat_pkg::NUM_W;
   localparam int DS = pat_pkg::DIV_STAGES;

   logic [NW-1:0] nq_ff  [DS];
   logic [NW-1:0] nq_in  [DS];
   logic [31:0]   rem_ff [DS];
   logic [31:0]   rem_in [DS];
   logic [31:0]   den_ff [DS];
   logic [31:0]   den_in_s [DS];
   logic          neg_ff [DS];
   logic          neg_in_s [DS];

   // Each stage shifts in one dividend bit and tries a subtract
   for (genvar j = 0; j < DS; j++) begin : g_stage
      logic [NW-1:0] nq_src;
      logic [31:0]   rem_src;
      logic [31:0]   den_src;
      logic          neg_src;
      logic [32:0]   trial;
      logic [32:0]   diff;
      logic          fit;
      if (j == 0) begin : g_first
         assign nq_src  = num_in;
         assign rem_src = '0;
         assign den_src = den_in;
         assign neg_src = neg_in;
      end else begin : g_next
         assign nq_src  = nq_ff[j-1];
         assign rem_src = rem_ff[j-1];
         assign den_src = den_ff[j-1];
         assign neg_src = neg_ff[j-1];
      end
      assign trial       = {rem_src, nq_src[NW-1]};
      assign diff        = trial - {1'b0, den_src};
      assign fit         = (trial >= {1'b0, den_src});
      assign nq_in[j]    = {nq_src[NW-2:0], fit};
      assign rem_in[j]   = fit ? diff[31:0] : trial[31:0];
      assign den_in_s[j] = den_src;
      assign neg_in_s[j] = neg_src;
   end

   // Advance every stage each cycle
   always_ff @(posedge clock) begin
      nq_ff  <= nq_in;
      rem_ff <= rem_in;
      den_ff <= den_in_s;
      neg_ff <= neg_in_s;
   end

   assign quo     = nq_ff[DS-1];
   assign neg_out = neg_ff[DS-1];

endmodule

// ===== hdl/pat_lane.sv =====
// One coordinate lane: translate, scale, rotate products and the shrink divider.
module pat_lane (
   input  logic                              clock,
   input  logic signed [31:0]                v_in,
   input  logic signed [31:0]                w_in,
   input  logic signed [31:0]                shift_in,
   input  logic [31:0]                       factor_in,
   input  logic signed [pat_pkg::TRIG_W-1:0] cos_in,
   input  logic signed [pat_pkg::TRIG_W-1:0] k_in,
   input  pat_pkg::mode_type                 mode_b,
   input  pat_pkg::mode_type                 mode_z,
   output logic [31:0]                       result
);

   localparam int NW = pat_pkg::NUM_W;
   localparam int LD = pat_pkg::LANE_DLY;

   logic signed [65:0] pcv_ff, pcv_in, pkw_ff, pkw_in;
   logic signed [64:0] pf_ff, pf_in;
   logic signed [32:0] tr_ff, tr_in;
   logic [31:0]        den;
   logic [31:0]        mag;
   logic [NW-1:0]      num_ff, num_in;
   logic [31:0]        den_ff;
   logic               neg_ff;

   logic signed [67:0] rsum, esum;
   logic [31:0]        b_in;
   logic [31:0]        dly_ff [LD];
   logic [NW-1:0]      quo;
   logic               qneg;

   // Stage A: products, sum and divider operands
   assign pcv_in = v_in * cos_in;
   assign pkw_in = w_in * k_in;
   assign pf_in  = v_in * $signed({1'b0, factor_in});
   assign tr_in  = {v_in[31], v_in} + {shift_in[31], shift_in};
   assign den    = (factor_in == '0) ? 32'd1 : factor_in;
   assign mag    = v_in[31] ? 32'(-v_in) : v_in;
   assign num_in = {mag, 16'd0} + NW'(den >> 1);

   always_ff @(posedge clock) begin
      pcv_ff <= pcv_in;
      pkw_ff <= pkw_in;
      pf_ff  <= pf_in;
      tr_ff  <= tr_in;
      num_ff <= num_in;
      den_ff <= den;
      neg_ff <= v_in[31];
   end

   // Stage B: round, saturate and pick the non-divide result
   assign rsum = 68'(pcv_ff) + 68'(pkw_ff) + (68'sd1 <<< 29);
   assign esum = 68'(pf_ff) + 68'sd32768;

   always_comb begin
      unique case (mode_b)
         pat_pkg::MODE_TRANSLATE: b_in = pat_pkg::sat32(68'(tr_ff));
         pat_pkg::MODE_ENLARGE:   b_in = pat_pkg::sat32(esum >>> 16);
         pat_pkg::MODE_ROTATE:    b_in = pat_pkg::sat32(rsum >>> 30);
         default:                 b_in = '0;
      endcase
   end

   // Hold the stage B result until the quotient lines up
   always_ff @(posedge clock) begin
      dly_ff[0] <= b_in;
      for (int k = 1; k < LD; k++) begin
         dly_ff[k] <= dly_ff[k-1];
      end
   end

   pat_div u_div (
      .clock   (clock),
      .num_in  (num_ff),
      .den_in  (den_ff),
      .neg_in  (neg_ff),
      .quo     (quo),
      .neg_out (qneg)
   );

   // Apply sign and clamp to the quotient in shrink mode, else pass the held stage B result
   always_comb begin
      if (mode_z == pat_pkg::MODE_SHRINK) begin
         if (quo[NW-1:31] != '0) begin
            result = qneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else begin
            result = qneg ? 32'(-quo[31:0]) : quo[31:0];
         end
      end else begin
         result = dly_ff[LD-1];
      end
   end

endmodule

// ===== hdl/point_affine_transform.sv =====
// Top level of the point affine transform block.
//
// Use: write the mode, shifts, factor and angle through the csr_ port while
// the block is idle. A write to the angle register starts a sin/cos
// computation on a shared CORDIC unit; busy is high meanwhile.
// Reset clears the registers (factor to 1.0, angle to 0) and runs the same
// computation, so busy stays high after reset is released until it completes.
//
// A vertex beat is accepted at a clock edge with start high and busy low,
// one beat per cycle is allowed. Each result shows on the rsp_ ports for
// one cycle with rsp_strobe high, in acceptance order. The path length is
// set by the 48-stage shrink divider plus the product and output stages;
// all modes take the same path length. The receiver cannot stall, so
// nothing holds the pipeline back.
module point_affine_transform (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [31:0]                     req_x_in,
   input  logic [31:0]                     req_y_in,
   input  logic                            req_last_in,
   output logic                            rsp_strobe,
   output logic [31:0]                     rsp_x_out,
   output logic [31:0]                     rsp_y_out,
   output logic                            rsp_last_out,
   input  logic                            csr_we,
   input  logic [pat_pkg::REG_IDX_W-1:0]   csr_index,
   input  logic [31:0]                     csr_wdata
);

   localparam int PD = pat_pkg::PIPE_DEPTH;

   pat_pkg::mode_type  mode_ff;
   logic signed [31:0] shift_x_ff, shift_y_ff;
   logic [31:0]        factor_ff;
   logic signed [25:0] angle_ff;
   logic               restart;
   pat_pkg::trig_type  trig;

   logic signed [31:0] x0_ff, y0_ff;
   logic               sb_valid_ff [PD];
   logic               sb_last_ff  [PD];
   pat_pkg::mode_type  sb_mode_ff  [PD];
   logic               accept;
   logic [31:0]        x_res, y_res;

   logic               rsp_strobe_ff;
   logic [31:0]        rsp_x_out_ff, rsp_y_out_ff;
   logic               rsp_last_out_ff;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= pat_pkg::MODE_TRANSLATE;
         shift_x_ff <= '0;
         shift_y_ff <= '0;
         factor_ff  <= 32'd65536;
         angle_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            pat_pkg::REG_MODE:    mode_ff    <= pat_pkg::mode_type'(csr_wdata[1:0]);
            pat_pkg::REG_SHIFT_X: shift_x_ff <= csr_wdata;
            pat_pkg::REG_SHIFT_Y: shift_y_ff <= csr_wdata;
            pat_pkg::REG_FACTOR:  factor_ff  <= csr_wdata;
            pat_pkg::REG_ANGLE:   angle_ff   <= csr_wdata[25:0];
            default: ;
         endcase
      end
   end

   assign restart = csr_we && (csr_index == pat_pkg::REG_ANGLE);

   pat_sincos u_sincos (
      .clock    (clock),
      .reset    (reset),
      .restart  (restart),
      .angle_in (angle_ff),
      .trig     (trig)
   );

   assign busy   = trig.busy;
   assign accept = start && !busy;

   // Capture the vertex beat
   always_ff @(posedge clock) begin
      x0_ff <= req_x_in;
      y0_ff <= req_y_in;
   end

   // Carry valid, last flag and mode alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PD; k++) begin
            sb_valid_ff[k] <= 1'b0;
         end
      end else begin
         sb_valid_ff[0] <= accept;
         for (int k = 1; k < PD; k++) begin
            sb_valid_ff[k] <= sb_valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      sb_last_ff[0] <= req_last_in;
      sb_mode_ff[0] <= mode_ff;
      for (int k = 1; k < PD; k++) begin
         sb_last_ff[k] <= sb_last_ff[k-1];
         sb_mode_ff[k] <= sb_mode_ff[k-1];
      end
   end

   pat_lane u_lane_x (
      .clock     (clock),
      .v_in      (x0_ff),
      .w_in      (y0_ff),
      .shift_in  (shift_x_ff),
      .factor_in (factor_ff),
      .cos_in    (trig.cos_v),
      .k_in      (trig.msin_v),
      .mode_b    (sb_mode_ff[1]),
      .mode_z    (sb_mode_ff[PD-1]),
      .result    (x_res)
   );

   pat_lane u_lane_y (
      .clock     (clock),
      .v_in      (y0_ff),
      .w_in      (x0_ff),
      .shift_in  (shift_y_ff),
      .factor_in (factor_ff),
      .cos_in    (trig.cos_v),
      .k_in      (trig.sin_v),
      .mode_b    (sb_mode_ff[1]),
      .mode_z    (sb_mode_ff[PD-1]),
      .result    (y_res)
   );

   // Drive the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= sb_valid_ff[PD-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_out_ff    <= x_res;
      rsp_y_out_ff    <= y_res;
      rsp_last_out_ff <= sb_last_ff[PD-1];
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_x_out    = rsp_x_out_ff;
   assign rsp_y_out    = rsp_y_out_ff;
   assign rsp_last_out = rsp_last_out_ff;

endmodule

// ===== hdl/pat_checker.sv =====
// Port-level checks of the point affine transform, bound to the top level.
module pat_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          req_last_in,
   input logic                          rsp_strobe,
   input logic                          rsp_last_out,
   input logic                          csr_we,
   input logic [pat_pkg::REG_IDX_W-1:0] csr_index
);

   localparam int LAT = pat_pkg::PIPE_DEPTH + 1;

   // Reset starts the sin/cos sequence
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low after reset");

   // An angle write starts the sin/cos sequence
   a_angle_busy: assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_index == pat_pkg::REG_ANGLE) |=> busy)
      else $error("busy low after angle write");

   // No result beat without an accepted vertex beat
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("result beat without accepted vertex");

   // Last flag follows its vertex
   a_last_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_last_out == $past(req_last_in, LAT)))
      else $error("last flag mismatch");

endmodule

bind point_affine_transform pat_checker u_pat_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the point affine transform block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [pat_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
   localparam logic [pat_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 60;
   localparam int SEGMENTS = 8;
   localparam int SEG_ITEMS = 160;
   localparam int ATAN_Q16 [pat_pkg::CORDIC_STEPS] = '{2949120, 1740967, 919879, 466945,
      234379, 117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic        last;
   } vertex_type;

   typedef struct {
      bit              is_csr;
      logic [2:0]      idx;
      logic [31:0]     val;
      logic [31:0]     x;
      logic [31:0]     y;
      logic            last;
      bit              typed;
      logic [31:0]     ex;
      logic [31:0]     ey;
   } step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_x_in = '0;
   logic [31:0] req_y_in = '0;
   logic        req_last_in = 1'b0;
   logic        rsp_strobe;
   logic [31:0] rsp_x_out;
   logic [31:0] rsp_y_out;
   logic        rsp_last_out;
   logic        csr_we = 1'b0;
   logic [pat_pkg::REG_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // predictor copy of the registers
   pat_pkg::mode_type cfg_mode;
   int          cfg_shift_x;
   int          cfg_shift_y;
   logic [31:0] cfg_factor;
   int          cfg_angle;

   vertex_type  pending_pts[$];
   int          errors = 0;
   int          cycles = 0;
   int          n_vertices = 0;
   int          n_results = 0;
   int          n_writes = 0;
   int          idle_pct = 0;

   point_affine_transform uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
      $display("MISMATCH %s: expected %h got %h at cycle %0d", what, want, got, cycles);
      errors++;
   endtask

   function automatic logic [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // cos and sin of the configured angle, Q2.30
   function automatic void trig_q30(input int a, output longint c, output longint s);
      int r;
      int z;
      bit flip;
      longint cx;
      longint cy;
      longint t;
      r = a % 23592960;
      flip = 0;
      cx = 652032875;
      cy = 0;
      if (r < 0) r += 23592960;
      if (r > 11796480) r -= 23592960;
      if (r > 5898240) begin
         r -= 11796480;
         flip = 1;
      end else if (r < -5898240) begin
         r += 11796480;
         flip = 1;
      end
      z = r;
      for (int i = 0; i < pat_pkg::CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            t = cx - (cy >>> i);
            cy = cy + (cx >>> i);
            z -= ATAN_Q16[i];
         end else begin
            t = cx + (cy >>> i);
            cy = cy - (cx >>> i);
            z += ATAN_Q16[i];
         end
         cx = t;
      end
      c = flip ? -cx : cx;
      s = flip ? -cy : cy;
   endfunction

   function automatic logic [31:0] enlarge(input longint v);
      longint p;
      p = v * longint'({32'b0, cfg_factor});
      return clamp32((p + 32768) >>> 16);
   endfunction

   function automatic logic [31:0] shrink(input longint v);
      longint unsigned d;
      longint unsigned m;
      longint unsigned q;
      d = (cfg_factor == 0) ? 64'd1 : {32'b0, cfg_factor};
      m = longint'(v < 0 ? -v : v) << 16;
      q = (m + d / 2) / d;
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return clamp32(v < 0 ? -longint'(q) : longint'(q));
   endfunction

   function automatic vertex_type transform_point(input logic [31:0] xi,
                                                  input logic [31:0] yi,
                                                  input logic li);
      vertex_type o;
      longint x;
      longint y;
      longint c;
      longint s;
      x = longint'(signed'(xi));
      y = longint'(signed'(yi));
      case (cfg_mode)
         pat_pkg::MODE_TRANSLATE: begin
            o.x = clamp32(x + cfg_shift_x);
            o.y = clamp32(y + cfg_shift_y);
         end
         pat_pkg::MODE_ENLARGE: begin
            o.x = enlarge(x);
            o.y = enlarge(y);
         end
         pat_pkg::MODE_SHRINK: begin
            o.x = shrink(x);
            o.y = shrink(y);
         end
         default: begin
            trig_q30(cfg_angle, c, s);
            o.x = clamp32((x * c - y * s + (64'sd1 <<< 29)) >>> 30);
            o.y = clamp32((x * s + y * c + (64'sd1 <<< 29)) >>> 30);
         end
      endcase
      o.last = li;
      return o;
   endfunction

   // hold off until every expected result has come back
   task automatic wait_drained();
      start <= 1'b0;
      while (pending_pts.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      n_writes++;
      case (idx)
         pat_pkg::REG_MODE:    cfg_mode = pat_pkg::mode_type'(val[1:0]);
         pat_pkg::REG_SHIFT_X: cfg_shift_x = val;
         pat_pkg::REG_SHIFT_Y: cfg_shift_y = val;
         pat_pkg::REG_FACTOR:  cfg_factor = val;
         pat_pkg::REG_ANGLE:   cfg_angle = {{6{val[25]}}, val[25:0]};
         default: ;
      endcase
      // the angle write kicks off the sin/cos pass; let busy rise first
      repeat (2) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // offer one vertex beat, optionally after an idle gap, and log its expectation
   task automatic send_vertex(input logic [31:0] x, input logic [31:0] y, input logic l,
                              input bit typed, input logic [31:0] ex, input logic [31:0] ey);
      int gap;
      vertex_type e;
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_x_in <= x;
      req_y_in <= y;
      req_last_in <= l;
      do @(posedge clock); while (busy);
      e = transform_point(x, y, l);
      if (typed) begin
         e.x = ex;
         e.y = ey;
      end
      pending_pts.push_back(e);
      n_vertices++;
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(3))
         0: return $urandom();
         1: case ($urandom_range(4))
               0: return 32'h0000_0000;
               1: return 32'h0000_0001;
               2: return 32'h7FFF_FFFF;
               3: return 32'h8000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         2: return $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
         default: return $urandom_range(32'h3FF_FFFF) - 32'h200_0000;
      endcase
   endfunction

   function automatic logic [31:0] rand_angle();
      case ($urandom_range(3))
         0: return $urandom();
         1: return $urandom_range(8) * 32'd2949120 - 32'd11796480 * 2;
         2: return ($urandom_range(1) ? 32'h01FF_FFFF : 32'h0200_0000);
         default: return $urandom_range(32'd47185920) - 32'd23592960;
      endcase
   endfunction

   // check each result beat against the oldest expectation
   always @(posedge clock) begin
      vertex_type e;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb: errors");
         $finish;
      end
      if (!reset && rsp_strobe) begin
         n_results++;
         if (pending_pts.size() == 0) begin
            report("unexpected beat x", 32'hx, rsp_x_out);
         end else begin
            e = pending_pts.pop_front();
            if (rsp_x_out !== e.x) report("x_out", e.x, rsp_x_out);
            if (rsp_y_out !== e.y) report("y_out", e.y, rsp_y_out);
            if (rsp_last_out !== e.last) begin
               report("last_out", {31'b0, e.last}, {31'b0, rsp_last_out});
            end
         end
      end
   end

   step_type plan[$];

   initial begin
      logic [31:0] mx;
      logic [31:0] mn;
      mx = 32'h7FFF_FFFF;
      mn = 32'h8000_0000;
      cfg_mode = pat_pkg::MODE_TRANSLATE;
      cfg_shift_x = 0;
      cfg_shift_y = 0;
      cfg_factor = 32'd65536;
      cfg_angle = 0;

      // directed table: register writes and vertices, some with typed results
      plan = '{
         '{0, 0, 0, mx, mn, 1, 1, mx, mn},
         '{0, 0, 0, 0, 0, 0, 1, 0, 0},
         '{1, pat_pkg::REG_SHIFT_X, mx, 0, 0, 0, 0, 0, 0},
         '{1, pat_pkg::REG_SHIFT_Y, mn, 0, 0, 0, 0, 0, 0},
         '{0, 0, 0, 1, 32'hFFFF_FFFF, 1, 1, mx, mn},
         '{0, 0, 0, 32'hFFFF_FFFF, 1, 0, 1, 32'h7FFF_FFFE, 32'h8000_0001},
         '{1, pat_pkg::REG_MODE, 32'hFFFF_FFFD, 0, 0, 0, 0, 0, 0},
         '{0, 0, 0, mx, mn, 1, 1, mx, mn},
         '{1, pat_pkg::REG_FACTOR, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0},
         '{0, 0, 0, mx, mn, 0, 1, mx, mn},
         '{0, 0, 0, 0, 0, 1, 1, 0, 0},
         '{1, pat_pkg::REG_MODE, pat_pkg::MODE_SHRINK, 0, 0, 0, 0, 0, 0},
         '{1, pat_pkg::REG_FACTOR, 0, 0, 0, 0, 0, 0, 0},
         '{0, 0, 0, 1, 32'hFFFF_FFFF, 0, 1, 32'h0001_0000, 32'hFFFF_0000},
         '{0, 0, 0, mx, mn, 1, 1, mx, mn},
         '{1, pat_pkg::REG_FACTOR, 32'd65536, 0, 0, 0, 0, 0, 0},
         '{0, 0, 0, 32'd12345, 32'hFFFF_FFF9, 0, 1, 32'd12345, 32'hFFFF_FFF9},
         '{1, REG_SPARE_LO, 32'hDEAD_BEEF, 0, 0, 0, 0, 0, 0},
         '{1, REG_SPARE_HI, 32'h1234_5678, 0, 0, 0, 0, 0, 0},
         '{1, pat_pkg::REG_MODE, pat_pkg::MODE_ROTATE, 0, 0, 0, 0, 0, 0},
         '{0, 0, 0, 32'h0001_0000, mn, 1, 0, 0, 0},
         '{1, pat_pkg::REG_ANGLE, 32'd5898240, 0, 0, 0, 0, 0, 0},
         '{0, 0, 0, mx, mn, 0, 0, 0, 0},
         '{1, pat_pkg::REG_ANGLE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0},
         '{0, 0, 0, 32'h0003_0000, 32'hFFFE_0000, 1, 0, 0, 0},
         '{1, pat_pkg::REG_ANGLE, 32'h01FF_FFFF, 0, 0, 0, 0, 0, 0},
         '{0, 0, 0, mn, mx, 0, 0, 0, 0},
         '{1, pat_pkg::REG_ANGLE, 32'h0200_0000, 0, 0, 0, 0, 0, 0},
         '{0, 0, 0, mn, mn, 1, 0, 0, 0},
         '{1, pat_pkg::REG_ANGLE, 32'd11796480, 0, 0, 0, 0, 0, 0},
         '{0, 0, 0, 32'h1234_5678, 32'hEDCB_A988, 0, 0, 0, 0}
      };

      // hold reset, then wait for the post-reset sin/cos pass
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      while (busy) @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_csr) csr_write(plan[i].idx, plan[i].val);
         else send_vertex(plan[i].x, plan[i].y, plan[i].last,
                          plan[i].typed, plan[i].ex, plan[i].ey);
      end

      // random segments: fresh registers, then a stream of vertices
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         idle_pct = (seg % 4 == 1) ? 60 : (seg % 4 == 3) ? 10 : 0;
         csr_write(pat_pkg::REG_SHIFT_X, rand_word());
         csr_write(pat_pkg::REG_SHIFT_Y, rand_word());
         csr_write(pat_pkg::REG_FACTOR, rand_word());
         csr_write(pat_pkg::REG_ANGLE, rand_angle());
         csr_write(pat_pkg::REG_MODE, {30'($urandom_range(32'h3FFF_FFFF)), 2'(seg)});
         for (int k = 0; k < SEG_ITEMS; k++) begin
            if (k == SEG_ITEMS / 2 && seg == 2) wait_drained();
            send_vertex(rand_word(), rand_word(), 1'($urandom_range(1)), 0, 0, 0);
         end
      end

      // drain, then give stray beats a chance to show
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d vertices, %0d results, %0d register writes over all four modes",
               n_vertices, n_results, n_writes);
      $display("with saturation extremes, zero factor, wide angles and idle gaps");
      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end
endmodule
